// File: rtl/core/vaf_pkg.sv
// Shared types, codes and character constants for the value to ASCII formatter.
package vaf_pkg;

  localparam int unsigned FuncW    = 3;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CharW    = 8;
  localparam int unsigned InDataW  = 40;  // func + value, padded to whole bytes
  localparam int unsigned OutDataW = 8;

  // Work register: 10 BCD digits, or the value top-aligned with a spare low byte.
  localparam int unsigned WorkW    = 40;
  localparam int unsigned CntW     = 6;   // holds up to 32 body characters
  localparam int unsigned BcdDigits = 10;

  localparam int unsigned ConvSteps = 32;
  localparam int unsigned IterW     = $clog2(ConvSteps);

  localparam logic [CharW-1:0] CharZero   = 8'h30;  // '0'
  localparam logic [CharW-1:0] CharUpperA = 8'h41;  // 'A'
  localparam logic [CharW-1:0] CharX      = 8'h78;  // 'x'
  localparam logic [CharW-1:0] CharPlus   = 8'h2B;  // '+'
  localparam logic [CharW-1:0] CharMinus  = 8'h2D;  // '-'
  localparam logic [3:0]       NibMask    = 4'hF;

  localparam logic [31:0] TrueStr  = 32'h74_72_75_65;     // "true"
  localparam logic [39:0] FalseStr = 40'h66_61_6C_73_65;  // "false"
  localparam logic [31:0] SignBit  = 32'h8000_0000;

  typedef enum logic [FuncW-1:0] {
    FN_CHAR  = 3'd0,
    FN_HEX0X = 3'd1,
    FN_HEX   = 3'd2,
    FN_BOOL  = 3'd3,
    FN_BIN   = 3'd4,
    FN_DEC   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_func_ok;
    logic in_is_dec;
    logic skip_more;
    logic last_char;
    logic out_free;
  } dp_sts_t;

  function automatic logic [CharW-1:0] hex_digit(input logic [3:0] nib);
    logic [3:0] n;
    n = nib & NibMask;
    if (n < 4'd10) return CharZero + CharW'(n);
    else           return CharUpperA + CharW'(n - 4'd10);
  endfunction

endpackage

// File: rtl/core/value_to_ascii_formatter_top.sv
// Top level of the value to ASCII formatter: controller plus datapath on stream ports.
// Formats one 32-bit word per input beat into a run of ASCII characters, one per output
// beat, with tlast on the final character; codes 6 and 7 are dropped without output.
// One item is in work at a time: it is loaded, passes a skip phase, then its characters go
// out one by one, each waiting while the output is stalled. Hex skips one leading zero
// byte per cycle (up to 3 bytes), binary one leading zero bit per cycle; each skipped bit
// is one character fewer.
// Decimal runs a bit-serial binary to BCD conversion over the 32-bit magnitude, then drops
// one leading zero digit per cycle (up to 9), then sends sign and digits. A new item is
// taken as soon as the last character has been loaded into the output register.
module value_to_ascii_formatter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [vaf_pkg::InDataW-1:0]    s_axis_tdata_i,   // [2:0] func, [34:3] value
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [vaf_pkg::OutDataW-1:0]   m_axis_tdata_o,   // [7:0] ch
  output logic                           m_axis_tlast_o    // last
);
  import vaf_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  vaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vaf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_func_i   (s_axis_tdata_i[FuncW-1:0]),
    .in_value_i  (s_axis_tdata_i[FuncW +: ValueW]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_ch_o    (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// File: rtl/core/vaf_ctrl.sv
// Controller state machine: sequences load, BCD conversion, leading-zero skip and emit.
module vaf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vaf_pkg::dp_sts_t   sts_i,
  output vaf_pkg::ctrl_cmd_t cmd_o
);
  import vaf_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        iter_d     = '0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (!sts_i.in_func_ok) state_d = ST_IDLE;
          else if (sts_i.in_is_dec) state_d = ST_CONV;
          else state_d = ST_SKIP;
        end
      end
      ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        iter_d          = iter_q + IterW'(1);
        if (iter_q == IterW'(ConvSteps - 1)) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (sts_i.skip_more) cmd_o.skip_step = 1'b1;
        else state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_char) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/vaf_datapath.sv
// Datapath: work shift register, double-dabble step, digit mapping and output register.
module vaf_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [vaf_pkg::FuncW-1:0]     in_func_i,
  input  logic [vaf_pkg::ValueW-1:0]    in_value_i,
  input  vaf_pkg::ctrl_cmd_t            cmd_i,
  output vaf_pkg::dp_sts_t              sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vaf_pkg::CharW-1:0]     out_ch_o,
  output logic                          out_last_o
);
  import vaf_pkg::*;

  func_e             func_q, func_d;
  logic [WorkW-1:0]  sr_q, sr_d;
  logic [ValueW-1:0] mag_q, mag_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [1:0]        pre_q, pre_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  ch_q, ch_d;
  logic              last_q, last_d;

  func_e             in_func;
  logic [WorkW-1:0]  bcd_adj;
  logic [3:0]        nib;
  logic [CharW-1:0]  body_ch;
  logic [CharW-1:0]  pre_ch;

  assign in_func = func_e'(in_func_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    sr_q   <= sr_d;
    mag_q  <= mag_d;
    cnt_q  <= cnt_d;
    pre_q  <= pre_d;
    neg_q  <= neg_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

  // Add 3 to every BCD digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      nib = sr_q[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_comb begin
    sts_o.in_func_ok = 1'b0;
    sts_o.in_is_dec  = 1'b0;
    unique case (in_func)
      FN_CHAR, FN_HEX0X, FN_HEX, FN_BOOL, FN_BIN: sts_o.in_func_ok = 1'b1;
      FN_DEC: begin
        sts_o.in_func_ok = 1'b1;
        sts_o.in_is_dec  = 1'b1;
      end
      default: sts_o.in_func_ok = 1'b0;
    endcase

    unique case (func_q)
      FN_HEX0X, FN_HEX: sts_o.skip_more = (cnt_q > CntW'(2)) && (sr_q[WorkW-1 -: 8] == '0);
      FN_BIN:           sts_o.skip_more = (cnt_q > CntW'(8)) && !sr_q[WorkW-1];
      FN_DEC:           sts_o.skip_more = (cnt_q > CntW'(1)) && (sr_q[WorkW-1 -: 4] == '0);
      default:          sts_o.skip_more = 1'b0;
    endcase

    sts_o.last_char = (pre_q == 2'd0) && (cnt_q == CntW'(1));
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    unique case (func_q)
      FN_HEX0X, FN_HEX: body_ch = hex_digit(sr_q[WorkW-1 -: 4]);
      FN_BIN:           body_ch = sr_q[WorkW-1] ? CharZero + CharW'(1) : CharZero;
      FN_DEC:           body_ch = CharZero + CharW'(sr_q[WorkW-1 -: 4]);
      default:          body_ch = sr_q[WorkW-1 -: 8];
    endcase
    if (func_q == FN_DEC) pre_ch = neg_q ? CharMinus : CharPlus;
    else                  pre_ch = (pre_q == 2'd2) ? CharZero : CharX;
  end

  always_comb begin
    func_d      = func_q;
    sr_d        = sr_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    pre_d       = pre_q;
    neg_d       = neg_q;
    ch_d        = ch_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.load) begin
      func_d = in_func;
      pre_d  = 2'd0;
      unique case (in_func)
        FN_CHAR: begin
          sr_d  = {in_value_i[7:0], 32'h0};
          cnt_d = CntW'(1);
        end
        FN_HEX0X: begin
          sr_d  = {in_value_i, 8'h0};
          cnt_d = CntW'(8);
          pre_d = 2'd2;
        end
        FN_HEX: begin
          sr_d  = {in_value_i, 8'h0};
          cnt_d = CntW'(8);
        end
        FN_BOOL: begin
          if (in_value_i[0]) begin
            sr_d  = {TrueStr, 8'h0};
            cnt_d = CntW'(4);
          end else begin
            sr_d  = FalseStr;
            cnt_d = CntW'(5);
          end
        end
        FN_BIN: begin
          sr_d  = {in_value_i, 8'h0};
          cnt_d = CntW'(32);
        end
        FN_DEC: begin
          sr_d  = '0;
          neg_d = (in_value_i & SignBit) != '0;
          mag_d = in_value_i[ValueW-1] ? (~in_value_i) + ValueW'(1) : in_value_i;
          cnt_d = CntW'(BcdDigits);
          pre_d = 2'd1;
        end
        default: cnt_d = '0;
      endcase
    end

    if (cmd_i.conv_step) begin
      sr_d  = {bcd_adj[WorkW-2:0], mag_q[ValueW-1]};
      mag_d = {mag_q[ValueW-2:0], 1'b0};
    end

    if (cmd_i.skip_step) begin
      unique case (func_q)
        FN_HEX0X, FN_HEX: begin
          sr_d  = sr_q << 8;
          cnt_d = cnt_q - CntW'(2);
        end
        FN_BIN: begin
          sr_d  = sr_q << 1;
          cnt_d = cnt_q - CntW'(1);
        end
        default: begin
          sr_d  = sr_q << 4;
          cnt_d = cnt_q - CntW'(1);
        end
      endcase
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      last_d      = sts_o.last_char;
      if (pre_q != 2'd0) begin
        ch_d  = pre_ch;
        pre_d = pre_q - 2'd1;
      end else begin
        ch_d  = body_ch;
        cnt_d = cnt_q - CntW'(1);
        unique case (func_q)
          FN_HEX0X, FN_HEX, FN_DEC: sr_d = sr_q << 4;
          FN_BIN:                   sr_d = sr_q << 1;
          default:                  sr_d = sr_q << 8;
        endcase
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ch_o    = ch_q;
  assign out_last_o  = last_q;

endmodule

// File: rtl/core/value_to_ascii_formatter_checker.sv
// Port-level checker for the value to ASCII formatter, bound to the top level.
module value_to_ascii_formatter_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [vaf_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [vaf_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                         m_axis_tlast_o
);
  import vaf_pkg::*;

  // A stalled output beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // A valid code keeps the input closed while its run is built.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i[FuncW-1:0] <= FN_DEC)
      |=> !s_axis_tready_o)
    else $error("input taken during a run");

  // Input opens only after the last character is loaded, so a pending beat then is the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && s_axis_tready_o |-> m_axis_tlast_o)
    else $error("input ready while a run is unfinished");

endmodule

bind value_to_ascii_formatter_top value_to_ascii_formatter_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
